@@ sv/lrdu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrdu_pkg;

   localparam int unsigned STATE_W = 31;
   localparam int unsigned RAW_W   = 32;
   localparam int unsigned FRAC_W  = 27;
   localparam int unsigned BOUND_W = 30;
   localparam int unsigned PROD_W  = 51;   // frac * 5^10 and state * 16807 both fit
   localparam int unsigned SCALE_W = 34;   // frac * 10^k >> 27, below 10^10
   localparam int unsigned POW5_W  = 24;
   localparam int unsigned EXP_W   = 4;
   localparam int unsigned PC_W    = 4;

   localparam logic [STATE_W-1:0] LCG_MULT  = 31'd16807;
   localparam logic [STATE_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
   localparam logic [STATE_W-1:0] SEED_MASK = 31'h5EEC_E66D;

   // Jump conditions of the control word.
   typedef enum logic [1:0] {
      COND_NONE,
      COND_PLAIN,   // plain draw: skip the range test
      COND_MISS,    // scaled value not below bound: draw again
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      logic            mul_state;   // prod <= state * 16807
      logic            mul_scale;   // prod <= frac * 5^k
      logic            fold;        // state <= prod mod (2^31-1)
      logic            keep_first;  // also latch first new state
      logic            form_raw;    // raw <= first + state[15:8]
      logic            shift;       // scaled <= prod >> (27-k)
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            done;        // hand result to output register
   } ucode_type;

   localparam logic [PC_W-1:0] STEP_DONE = 4'd8;

   // Control store.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{mul_state: 1'b0, mul_scale: 1'b0, fold: 1'b0, keep_first: 1'b0,
            form_raw: 1'b0, shift: 1'b0, cond: COND_NONE, target: '0, done: 1'b0};
      case (pc)
         4'd0: w.mul_state = 1'b1;
         4'd1: begin
            w.fold       = 1'b1;
            w.keep_first = 1'b1;
         end
         4'd2: w.mul_state = 1'b1;
         4'd3: w.fold = 1'b1;
         4'd4: begin
            w.form_raw = 1'b1;
            w.cond     = COND_PLAIN;
            w.target   = STEP_DONE;
         end
         4'd5: w.mul_scale = 1'b1;
         4'd6: w.shift = 1'b1;
         4'd7: begin
            w.cond   = COND_MISS;
            w.target = 4'd0;
         end
         default: w.done = 1'b1;
      endcase
      return w;
   endfunction

   // 5^k; 10^k = 5^k * 2^k, the 2^k goes into the shift.
   function automatic logic [POW5_W-1:0] pow5(input logic [EXP_W-1:0] k);
      logic [POW5_W-1:0] v;
      case (k)
         4'd1:    v = 24'd5;
         4'd2:    v = 24'd25;
         4'd3:    v = 24'd125;
         4'd4:    v = 24'd625;
         4'd5:    v = 24'd3125;
         4'd6:    v = 24'd15625;
         4'd7:    v = 24'd78125;
         4'd8:    v = 24'd390625;
         4'd9:    v = 24'd1953125;
         4'd10:   v = 24'd9765625;
         default: v = 24'd1;
      endcase
      return v;
   endfunction

   function automatic logic [BOUND_W-1:0] pow10(input logic [EXP_W-1:0] k);
      logic [BOUND_W-1:0] v;
      case (k)
         4'd1:    v = 30'd10;
         4'd2:    v = 30'd100;
         4'd3:    v = 30'd1000;
         4'd4:    v = 30'd10000;
         4'd5:    v = 30'd100000;
         4'd6:    v = 30'd1000000;
         4'd7:    v = 30'd10000000;
         4'd8:    v = 30'd100000000;
         4'd9:    v = 30'd1000000000;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

   // Smallest k >= 1 with 10^k > bound.
   function automatic logic [EXP_W-1:0] decade_exp(input logic [BOUND_W-1:0] bound);
      logic [EXP_W-1:0] k;
      k = 4'd1;
      for (int i = 1; i <= 9; i++) begin
         if (bound >= pow10(EXP_W'(i))) k = k + 4'd1;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ sv/lrdu_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lrdu_req_if;
   import lrdu_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [BOUND_W-1:0] upper_bound;

   modport source (output valid, output command, output upper_bound, input ready);
   modport sink   (input valid, input command, input upper_bound, output ready);
endinterface

`default_nettype wire

@@ sv/lrdu_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lrdu_rsp_if;
   import lrdu_pkg::*;
   logic               valid;
   logic               ready;
   logic [RAW_W-1:0]   raw_value;
   logic [FRAC_W-1:0]  fraction;
   logic [BOUND_W-1:0] ranged_value;

   modport source (output valid, output raw_value, output fraction, output ranged_value,
                   input ready);
   modport sink   (input valid, input raw_value, input fraction, input ranged_value,
                   output ready);
endinterface

`default_nettype wire

@@ sv/lcg_random_draw_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | handshake    | payload
// ----------+-----+--------------+-----------------------------------------
// req_chan  | in  | valid/ready  | command, upper_bound
// rsp_chan  | out | valid/ready  | raw_value, fraction, ranged_value
// csr_*     | in  | write enable | 31-bit seed, loads state = seed ^ mask
//
// One request at a time, run by a 9-word microprogram over one shared
// 31x24 multiplier and a mod (2^31-1) fold. A plain draw steps the state
// twice through the multiplier/fold chain and forms its raw value; a ranged
// draw then scales the fraction and repeats whole draws until the scaled
// value is below the bound; a zero bound goes to the final step with no draw.
// Synchronous active-high reset; state resets to 0x5EECE66D.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stalled result holds the sequencer at its
// final step.

module lcg_random_draw_unit
   import lrdu_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   lrdu_req_if.sink            req_chan,
   lrdu_rsp_if.source          rsp_chan,
   input  wire                 csr_write_enable,
   input  wire [STATE_W-1:0]   csr_write_data
);

   // sequencer
   logic                busy_ff, busy_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   ucode_type           uc;

   // datapath
   logic [STATE_W-1:0]  state_ff, state_in;
   logic [STATE_W-1:0]  first_ff, first_in;
   logic [RAW_W-1:0]    raw_ff, raw_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SCALE_W-1:0]  scaled_ff, scaled_in;
   logic                cmd_ff, cmd_in;
   logic [BOUND_W-1:0]  bound_ff, bound_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic [BOUND_W-1:0]  rsp_ranged_ff, rsp_ranged_in;

   logic                req_accept;
   logic                rsp_free;
   logic [STATE_W-1:0]  mul_a;
   logic [POW5_W-1:0]   mul_b;
   logic [54:0]         mul_full;
   logic [RAW_W-1:0]    fold_sum;
   logic [STATE_W-1:0]  fold_res;
   logic [4:0]          shamt;
   logic                miss;

   assign req_chan.ready        = ~busy_ff;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.raw_value    = rsp_raw_ff;
   assign rsp_chan.fraction     = rsp_raw_ff[FRAC_W-1:0];
   assign rsp_chan.ranged_value = rsp_ranged_ff;

   assign req_accept = req_chan.valid & ~busy_ff;
   assign rsp_free   = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      uc = ucode_rom(pc_ff);

      // shared multiplier: state step or fraction scaling
      mul_a    = uc.mul_scale ? {4'd0, raw_ff[FRAC_W-1:0]} : state_ff;
      mul_b    = uc.mul_scale ? pow5(exp_ff) : POW5_W'(LCG_MULT);
      mul_full = 55'(mul_a) * 55'(mul_b);

      // 2^31 == 1 mod (2^31-1): add high and low parts, one correction
      fold_sum = {17'd0, prod_ff[45:31]} + {1'b0, prod_ff[30:0]};
      fold_res = (fold_sum >= {1'b0, LCG_MOD}) ? STATE_W'(fold_sum - {1'b0, LCG_MOD})
                                              : fold_sum[STATE_W-1:0];

      shamt = 5'(FRAC_W) - {1'b0, exp_ff};
      miss  = scaled_ff >= {4'd0, bound_ff};

      busy_in       = busy_ff;
      pc_in         = pc_ff;
      state_in      = state_ff;
      first_in      = first_ff;
      raw_in        = raw_ff;
      prod_in       = prod_ff;
      scaled_in     = scaled_ff;
      cmd_in        = cmd_ff;
      bound_in      = bound_ff;
      exp_in        = exp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_ranged_in = rsp_ranged_ff;

      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      if (csr_write_enable) state_in = csr_write_data ^ SEED_MASK;

      if (req_accept) begin
         busy_in   = 1'b1;
         cmd_in    = req_chan.command;
         bound_in  = req_chan.upper_bound;
         exp_in    = decade_exp(req_chan.upper_bound);
         scaled_in = '0;   // plain draws report 0 as ranged value
         if (req_chan.command && req_chan.upper_bound == '0) begin
            // zero bound: no draw, all-zero result
            raw_in = '0;
            pc_in  = STEP_DONE;
         end else begin
            pc_in = '0;
         end
      end else if (busy_ff) begin
         if (uc.mul_state || uc.mul_scale) prod_in = mul_full[PROD_W-1:0];
         if (uc.fold) begin
            state_in = fold_res;
            if (uc.keep_first) first_in = fold_res;
         end
         if (uc.form_raw) raw_in = {1'b0, first_ff} + {24'd0, state_ff[15:8]};
         if (uc.shift) scaled_in = SCALE_W'(prod_ff >> shamt);

         pc_in = pc_ff + 4'd1;
         case (uc.cond)
            COND_PLAIN:  if (!cmd_ff) pc_in = uc.target;
            COND_MISS:   if (miss) pc_in = uc.target;
            COND_ALWAYS: pc_in = uc.target;
            default:     ;
         endcase

         if (uc.done) begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = raw_ff;
               rsp_ranged_in = scaled_ff[BOUND_W-1:0];
               busy_in       = 1'b0;
            end else begin
               pc_in = pc_ff;   // hold until output register frees
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SEED_MASK;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      first_ff      <= first_in;
      raw_ff        <= raw_in;
      prod_ff       <= prod_in;
      scaled_ff     <= scaled_in;
      cmd_ff        <= cmd_in;
      bound_ff      <= bound_in;
      exp_ff        <= exp_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for lcg_random_draw_unit.
// Requests go in through a queue that the stimulus process fills. A falling-edge
// driver presents them, and a rising-edge monitor predicts each accepted request
// and checks each response in order.
module tb;
   import lrdu_pkg::*;

   // Request commands
   localparam logic CMD_PLAIN  = 1'b0;
   localparam logic CMD_RANGED = 1'b1;

   // Generator constants, kept apart from the package so the prediction stands alone
   localparam longint unsigned PM_MULT = 64'd16807;
   localparam longint unsigned PM_MOD  = 64'd2147483647;
   localparam logic [30:0] SEED_SCRAMBLE = 31'h5EEC_E66D;
   // Seeds that land the state on 0 and on the modulus
   localparam logic [30:0] SEED_STATE_ZERO = 31'h5EEC_E66D;
   localparam logic [30:0] SEED_STATE_MOD  = 31'h2113_1992;

   localparam int IDLE_PCT      = 18;
   localparam int STALL_LIMIT   = 20000;   // ranged retries at 10% hit rate stay far below
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 142;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic               command;
      logic [BOUND_W-1:0] bound;
   } draw_req_type;

   typedef struct packed {
      logic [RAW_W-1:0]   raw;
      logic [FRAC_W-1:0]  frac;
      logic [BOUND_W-1:0] ranged;
   } draw_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [STATE_W-1:0] csr_write_data;

   lrdu_req_if req_bus ();
   lrdu_rsp_if rsp_bus ();

   lcg_random_draw_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Pending requests and the responses they should produce
   draw_req_type    pending_reqs[$];
   draw_result_type expected_draws[$];

   logic [31:0] gen_state = 32'h5EEC_E66D;   // predicted generator state, reset value
   logic        req_taken = 1'b0;            // monitor -> driver: front request accepted
   logic        calm = 1'b0;                 // no idling on either side while set

   int error_count   = 0;
   int checked_count = 0;
   int plain_count   = 0;
   int ranged_count  = 0;
   int zero_count    = 0;
   int seed_loads    = 0;
   int stall_cycles  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // One Park-Miller step, product formed at 64 bits
   function automatic logic [31:0] pm_step(input logic [31:0] s);
      longint unsigned prod;
      prod = PM_MULT * longint'(s);
      return 32'(prod % PM_MOD);
   endfunction

   // A draw steps twice: first state plus bits 15:8 of the second
   function automatic logic [RAW_W-1:0] draw_pair();
      logic [31:0] first;
      gen_state = pm_step(gen_state);
      first     = gen_state;
      gen_state = pm_step(gen_state);
      return first + {24'd0, gen_state[15:8]};
   endfunction

   function automatic draw_result_type predict_draw(input draw_req_type rq);
      draw_result_type    r;
      logic [RAW_W-1:0]   raw;
      longint unsigned    decade;
      longint unsigned    scaled;
      logic [BOUND_W-1:0] t;
      r = '0;
      if (rq.command == CMD_PLAIN) begin
         raw    = draw_pair();
         r.raw  = raw;
         r.frac = raw[FRAC_W-1:0];
      end else if (rq.bound != '0) begin
         // smallest power of ten above the bound, at least 10
         decade = 10;
         t      = BOUND_W'(rq.bound / 10);
         while (t != '0) begin
            t      = BOUND_W'(t / 10);
            decade = decade * 10;
         end
         // whole draws repeat until the scaled fraction lands below the bound;
         // a stuck-at-zero generator yields 0, which is taken at once
         scaled = longint'(rq.bound);
         while (scaled >= longint'(rq.bound)) begin
            raw    = draw_pair();
            scaled = (longint'(raw[FRAC_W-1:0]) * decade) >> FRAC_W;
         end
         r.raw    = raw;
         r.frac   = raw[FRAC_W-1:0];
         r.ranged = scaled[BOUND_W-1:0];
      end
      // ranged with zero bound: no draw, all fields 0, state untouched
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: inputs change on the falling edge
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         // valid holds until the request is taken, then the next one may follow
         req_taken = 1'b0;
         if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_bus.valid       <= 1'b1;
            req_bus.command     <= pending_reqs[0].command;
            req_bus.upper_bound <= pending_reqs[0].bound;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------------
   // Monitor: sample at the rising edge, predict on request, check on response
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      draw_result_type got;
      draw_result_type want;
      draw_req_type    taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.raw_value, rsp_bus.fraction, rsp_bus.ranged_value};
            checked_count++;
            if (expected_draws.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("%0t: response with none outstanding: raw %0d frac %0d ranged %0d",
                           $time, got.raw, got.frac, got.ranged);
            end else begin
               want = expected_draws.pop_front();
               if (got != want) begin
                  error_count++;
                  if (error_count <= REPORT_MAX) begin
                     $display("%0t: mismatch raw exp %0d act %0d, frac exp %0d act %0d",
                              $time, want.raw, got.raw, want.frac, got.frac);
                     $display("   ranged exp %0d act %0d", want.ranged, got.ranged);
                  end
               end
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            taken = '{req_bus.command, req_bus.upper_bound};
            expected_draws.push_back(predict_draw(taken));
            void'(pending_reqs.pop_front());
            req_taken = 1'b1;
            if (taken.command == CMD_PLAIN) plain_count++;
            else ranged_count++;
            if (taken.command == CMD_RANGED && taken.bound == '0) zero_count++;
         end

         // watchdog: only counts while something is outstanding
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (pending_reqs.size() == 0 && expected_draws.size() == 0))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   function automatic void queue_request(input logic cmd, input logic [BOUND_W-1:0] bound);
      pending_reqs.push_back('{cmd, bound});
   endfunction

   // Seed writes only while the unit is idle
   task automatic load_seed(input logic [30:0] seed);
      while (pending_reqs.size() != 0 || expected_draws.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= seed;
      gen_state = {1'b0, seed ^ SEED_SCRAMBLE};
      seed_loads++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          p;
      int          i;
      int          k;
      int unsigned lo;
      int unsigned hi;
      int unsigned sel;
      logic [BOUND_W-1:0] bound;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_PLAIN;
      req_bus.upper_bound  = '0;
      rsp_bus.ready        = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: state as after reset, bound extremes and decade edges
      queue_request(CMD_PLAIN, '0);
      queue_request(CMD_PLAIN, '1);               // bound is ignored on a plain draw
      queue_request(CMD_RANGED, '0);              // zero bound: no draw, all zero
      queue_request(CMD_RANGED, 30'd1);           // 10% hit rate, most retries
      queue_request(CMD_RANGED, 30'd9);
      queue_request(CMD_RANGED, 30'd10);
      queue_request(CMD_RANGED, 30'd99999);
      queue_request(CMD_RANGED, 30'd536870912);
      queue_request(CMD_RANGED, 30'd999999999);
      queue_request(CMD_RANGED, 30'd1000000000);  // decade 10^10
      queue_request(CMD_RANGED, '1);

      // Stuck-at-zero state
      load_seed(SEED_STATE_ZERO);
      queue_request(CMD_PLAIN, '0);
      queue_request(CMD_RANGED, 30'd5);
      queue_request(CMD_RANGED, '0);
      queue_request(CMD_RANGED, '1);

      // State equal to the modulus falls to zero on its first step
      load_seed(SEED_STATE_MOD);
      queue_request(CMD_RANGED, 30'd7);
      queue_request(CMD_PLAIN, '1);

      load_seed(31'h7FFF_FFFF);
      queue_request(CMD_PLAIN, '0);
      queue_request(CMD_RANGED, 30'd3);

      // Random phases, each behind a new seed; one phase runs with no idling
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)
            load_seed('0);
         else if (p == RANDOM_PHASES - 1)
            load_seed(31'h7FFF_FFFF);
         else
            load_seed(31'($urandom));
         calm = (p == 3);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 45) begin
               queue_request(CMD_PLAIN, 30'($urandom));
            end else begin
               sel = $urandom_range(99);
               if (sel < 6) begin
                  bound = '0;
               end else if (sel < 20) begin
                  bound = 30'($urandom_range(20, 1));
               end else begin
                  // pick a decade, then a bound inside it
                  k  = $urandom_range(10, 1);
                  lo = 1;
                  repeat (k - 1) lo = lo * 10;
                  hi = (k == 10) ? 32'h3FFF_FFFF : lo * 10 - 1;
                  bound = 30'($urandom_range(hi, lo));
               end
               queue_request(CMD_RANGED, bound);
            end
         end
      end

      while (pending_reqs.size() != 0 || expected_draws.size() != 0)
         @(negedge clock);
      calm = 1'b0;
      repeat (40) @(negedge clock);   // catch any stray response

      $display("Ran %0d plain and %0d ranged requests (%0d zero-bound) across %0d seed loads",
               plain_count, ranged_count, zero_count, seed_loads);
      $display("%0d responses checked, %0d failures", checked_count, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ lcg_random_draw_unit.f @@
sv/lrdu_pkg.sv
sv/lrdu_req_if.sv
sv/lrdu_rsp_if.sv
sv/lcg_random_draw_unit.sv
tb/tb.sv
